// ----- design/bvl_pkg.sv -----
// ----------------------------------------------------------------------------
// bvl_pkg
// Types and codes shared by the bounded value list controller, datapath and
// top level.
// ----------------------------------------------------------------------------
package bvl_pkg;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_INSERT,
    OP_REMOVE,
    OP_FIND
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_FULL,
    ST_PRESENT,
    ST_MISSING
  } status_t;

  typedef struct packed {
    op_t                operation;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic               found;
    logic signed [31:0] found_value;
    logic [4:0]         entry_total;
  } rsp_t;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_SCAN,
    FSM_DRAIN,
    FSM_COMMIT
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;   // write an empty slot at the pointer, advance
    logic load;       // capture request, restart pointer and scan flags
    logic scan_read;  // read slot at the pointer, advance
    logic commit;     // apply operation, load response register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ptr_last;   // pointer sits on the last slot
    logic out_busy;   // response register holds a transaction not yet taken
  } stat_t;

endpackage

// ----- design/bvl_ctrl.sv -----
// ----------------------------------------------------------------------------
// bvl_ctrl
// Sequencer: clearing pass after reset, then accept / scan / drain / commit
// for each request.
// ----------------------------------------------------------------------------
module bvl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bvl_pkg::stat_t stat,
  output bvl_pkg::cmd_t  cmd
);

  bvl_pkg::fsm_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bvl_pkg::FSM_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      bvl_pkg::FSM_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.ptr_last) begin
          state_next = bvl_pkg::FSM_IDLE;
        end
      end
      bvl_pkg::FSM_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = bvl_pkg::FSM_SCAN;
        end
      end
      bvl_pkg::FSM_SCAN: begin
        cmd.scan_read = 1'b1;
        if (stat.ptr_last) begin
          state_next = bvl_pkg::FSM_DRAIN;
        end
      end
      bvl_pkg::FSM_DRAIN: begin
        state_next = bvl_pkg::FSM_COMMIT;
      end
      bvl_pkg::FSM_COMMIT: begin
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_next = bvl_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = bvl_pkg::FSM_CLEAR;
      end
    endcase
  end

endmodule

// ----- design/bvl_datapath.sv -----
// ----------------------------------------------------------------------------
// bvl_datapath
// Slot memory (valid bit + value), scan pointer, match/free trackers, entry
// count and response register.
// ----------------------------------------------------------------------------
module bvl_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  bvl_pkg::cmd_t  cmd,
  output bvl_pkg::stat_t stat,
  input  bvl_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bvl_pkg::rsp_t  rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

  // slot word: [32] valid, [31:0] value
  logic [32:0]   mem [CAPACITY];
  logic [32:0]   rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [32:0]   wdata;

  logic [AW-1:0] ptr;
  logic          rd_pend;
  logic [AW-1:0] rd_idx;

  bvl_pkg::op_t  op;
  logic [31:0]   val;
  logic          hit_found, free_found;
  logic [AW-1:0] hit_idx, free_idx;
  logic [CW-1:0] count, count_next;

  bvl_pkg::rsp_t rsp_next;
  logic [CW+4:0] count_wide;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[ptr];
  end

  // pointer: sweeps slots during clear and scan
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      ptr <= '0;
    end else if (cmd.clr_step || cmd.scan_read) begin
      ptr <= (ptr == LAST_SLOT) ? '0 : ptr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_read;
    end
    rd_idx <= ptr;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op  <= req.operation;
      val <= req.value;
    end
  end

  // lowest matching valid slot and lowest free slot
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (rd_pend) begin
      if (rdata[32]) begin
        if (!hit_found && rdata[31:0] == val) begin
          hit_found <= 1'b1;
        end
      end else if (!free_found) begin
        free_found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend && rdata[32] && !hit_found && rdata[31:0] == val) begin
      hit_idx <= rd_idx;
    end
    if (rd_pend && !rdata[32] && !free_found) begin
      free_idx <= rd_idx;
    end
  end

  // operation decode and write-back
  always_comb begin
    we         = 1'b0;
    waddr      = ptr;
    wdata      = '0;
    count_next = count;
    rsp_next   = '0;
    rsp_next.found = hit_found;
    if (cmd.clr_step) begin
      we = 1'b1;
    end
    unique case (op)
      bvl_pkg::OP_ADD, bvl_pkg::OP_INSERT: begin
        if (op == bvl_pkg::OP_INSERT && hit_found) begin
          rsp_next.status = bvl_pkg::ST_PRESENT;
        end else if (free_found) begin
          rsp_next.status = bvl_pkg::ST_DONE;
          count_next      = count + CW'(1);
          if (cmd.commit) begin
            we    = 1'b1;
            waddr = free_idx;
            wdata = {1'b1, val};
          end
        end else begin
          rsp_next.status = bvl_pkg::ST_FULL;
        end
      end
      bvl_pkg::OP_REMOVE: begin
        if (hit_found) begin
          rsp_next.status = bvl_pkg::ST_DONE;
          count_next      = count - CW'(1);
          if (cmd.commit) begin
            we    = 1'b1;
            waddr = hit_idx;
            wdata = {1'b0, val};
          end
        end else begin
          rsp_next.status = bvl_pkg::ST_MISSING;
        end
      end
      bvl_pkg::OP_FIND: begin
        if (hit_found) begin
          rsp_next.status      = bvl_pkg::ST_DONE;
          rsp_next.found_value = val;
        end else begin
          rsp_next.status = bvl_pkg::ST_MISSING;
        end
      end
      default: begin
        rsp_next.status = bvl_pkg::ST_MISSING;
      end
    endcase
    count_wide           = {5'b0, count_next};
    rsp_next.entry_total = count_wide[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.commit) begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  assign stat.ptr_last = (ptr == LAST_SLOT);
  assign stat.out_busy = rsp_valid && !rsp_ready;

endmodule

// ----- design/bounded_value_list_core.sv -----
// ----------------------------------------------------------------------------
// bounded_value_list_core
// A request is taken only in the idle state and is answered after its scan,
//   drain and commit; the scan reads one slot per cycle through the single
//   read port of the slot memory.
// Reset: a clearing pass empties every slot; req_ready stays low until it ends.
// ----------------------------------------------------------------------------
module bounded_value_list_core #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bvl_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bvl_pkg::rsp_t rsp
);

  // Flow per transaction:
  //   IDLE   - request captured, scan pointer and trackers reset
  //   SCAN   - one slot read per cycle; the compare runs in the cycle after
  //            the read (registered memory output)
  //   DRAIN  - last slot compared
  //   COMMIT - slot written (add / insert to lowest free slot, remove clears
  //            the lowest matching slot), count updated, response loaded;
  //            waits here while the previous response is still unclaimed
  // The response register lets a new request be taken while the previous
  // response is still waiting downstream.

  bvl_pkg::cmd_t  cmd;
  bvl_pkg::stat_t stat;

  bvl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bvl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // A new response only appears from a commit.
  a_rsp_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(cmd.commit))
    else $error("response valid without commit");

  // Commit never overwrites an unclaimed response.
  a_commit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(rsp_valid && !rsp_ready))
    else $error("commit overwrote pending response");

  // Every accepted request starts a scan on the next cycle.
  a_load_then_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.scan_read)
    else $error("scan did not follow request");

  // Commit and a clearing step never meet at the write port.
  a_write_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.commit && cmd.clr_step))
    else $error("write port conflict");

endmodule
